// ===== rtl/lta_pkg.sv =====
// Shared types and codes for the latched two-operand ALU.
package lta_pkg;

	// Default datapath width of the operand registers and arithmetic unit.
	localparam int DATA_WIDTH_DEF = 64;

	// Field widths of the configuration registers and the write port.
	localparam int OP_W      = 3;
	localparam int WCODE_W   = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 3;

	// Width of a working-width value in bits (wide enough to hold 64).
	localparam int WW_W = 7;

	// Fixed widths of the stream payloads.
	localparam int OPERAND_W = 64;
	localparam int RESULT_W  = 64;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ADD = 3'd0;
	localparam logic [OP_W-1:0] OP_SUB = 3'd1;
	localparam logic [OP_W-1:0] OP_MUL = 3'd2;
	localparam logic [OP_W-1:0] OP_DIV = 3'd3;
	localparam logic [OP_W-1:0] OP_MIN = 3'd4;
	localparam logic [OP_W-1:0] OP_MAX = 3'd5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_OP_SELECT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_CODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IS_SIGNED  = 2'd2;

	// Register reset values.
	localparam logic [OP_W-1:0]    OP_SELECT_RST  = OP_ADD;
	localparam logic [WCODE_W-1:0] WIDTH_CODE_RST = 2'd3;
	localparam logic               IS_SIGNED_RST  = 1'b1;

	// Configuration handed to the arithmetic unit.
	typedef struct packed {
		logic [OP_W-1:0]    op_select;
		logic [WCODE_W-1:0] width_code;
		logic               is_signed;
	} lta_cfg_t;

endpackage

// ===== rtl/lta_alu.sv =====
// Sequenced arithmetic unit: one shared adder runs add, subtract, compare, multiply and divide.
module lta_alu #(
	parameter int DATA_WIDTH = lta_pkg::DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lta_pkg::lta_cfg_t             cfg,
	input  logic                          start,
	input  logic [DATA_WIDTH-1:0]         a_raw,
	input  logic [DATA_WIDTH-1:0]         b_raw,
	output logic                          idle,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [lta_pkg::RESULT_W-1:0]  res_data
);
	import lta_pkg::*;

	localparam int DW     = DATA_WIDTH;
	localparam int ADD_W  = DW + 2;
	localparam int IDX_W  = $clog2(DW);
	localparam int CNT_W  = $clog2(DW);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DW - 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_NEGA = 3'd2;
	localparam logic [2:0] S_NEGB = 3'd3;
	localparam logic [2:0] S_ITER = 3'd4;
	localparam logic [2:0] S_FIX  = 3'd5;

	logic [2:0]          state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                res_valid_q;
	logic [RESULT_W-1:0] res_q;
	logic [DW-1:0]       a_q;
	logic [DW-1:0]       b_q;
	logic [DW-1:0]       acc_q;
	logic [DW-1:0]       q_q;
	logic                neg_q;

	logic [WW_W-1:0]     w_full;
	logic [WW_W-1:0]     w_lim;
	logic [DW-1:0]       a_e;
	logic [DW-1:0]       b_e;
	logic [ADD_W-1:0]    add_x;
	logic [ADD_W-1:0]    add_y;
	logic                add_sub;
	logic [ADD_W-1:0]    sum;
	logic                sum_neg;
	logic [DW:0]         shifted;
	logic [DW-1:0]       r;
	logic [DW-1:0]       r_e;
	logic                fix_load;

	// Truncate to the working width, then sign- or zero-extend back to the datapath width.
	function automatic logic [DW-1:0] extend(input logic [DW-1:0] x, input logic [WW_W-1:0] w,
			input logic sg);
		logic [DW-1:0] e;
		logic          fill;
		fill = sg & x[IDX_W'(w - WW_W'(1))];
		for (int i = 0; i < DW; i++) begin
			e[i] = (i < 32'(w)) ? x[i] : fill;
		end
		return e;
	endfunction

	// Working width is 8 << width_code, limited to the datapath width.
	assign w_full = WW_W'(8) << cfg.width_code;
	assign w_lim  = (32'(w_full) > DW) ? WW_W'(DW) : w_full;
	assign a_e    = extend(a_raw, w_lim, cfg.is_signed);
	assign b_e    = extend(b_raw, w_lim, cfg.is_signed);

	// Operand routing into the shared adder.
	assign shifted = {acc_q, q_q[DW-1]};
	always_comb begin
		add_x   = cfg.is_signed ? ADD_W'($signed(a_q)) : ADD_W'(a_q);
		add_y   = cfg.is_signed ? ADD_W'($signed(b_q)) : ADD_W'(b_q);
		add_sub = (cfg.op_select != OP_ADD);
		case (state_q)
			S_NEGA: begin
				add_x   = '0;
				add_y   = ADD_W'(a_q);
				add_sub = 1'b1;
			end
			S_NEGB: begin
				add_x   = '0;
				add_y   = ADD_W'(b_q);
				add_sub = 1'b1;
			end
			S_ITER: begin
				if (cfg.op_select == OP_MUL) begin
					add_x   = ADD_W'(acc_q);
					add_y   = ADD_W'(a_q);
					add_sub = 1'b0;
				end else begin
					add_x   = ADD_W'(shifted);
					add_y   = ADD_W'(b_q);
					add_sub = 1'b1;
				end
			end
			S_FIX: begin
				if (cfg.op_select == OP_DIV) begin
					add_x   = '0;
					add_y   = ADD_W'(q_q);
					add_sub = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign sum     = add_x + (add_sub ? ~add_y : add_y) + ADD_W'(add_sub);
	assign sum_neg = sum[ADD_W-1];

	// Final result selection before width limiting.
	always_comb begin
		case (cfg.op_select)
			OP_ADD, OP_SUB: r = sum[DW-1:0];
			OP_MUL:         r = acc_q;
			OP_DIV:         r = neg_q ? sum[DW-1:0] : q_q;
			OP_MIN:         r = sum_neg ? a_q : b_q;
			OP_MAX:         r = sum_neg ? b_q : a_q;
			default:        r = '0;
		endcase
	end
	assign r_e = extend(r, w_lim, cfg.is_signed);

	// The result moves to the output register once that register is free.
	assign fix_load = (state_q == S_FIX) && (!res_valid_q || res_ready);

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (fix_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					cnt_q <= CNT_MAX;
					case (cfg.op_select)
						OP_ADD, OP_SUB, OP_MIN, OP_MAX: state_q <= S_FIX;
						OP_MUL: state_q <= S_ITER;
						OP_DIV: state_q <= (b_e == '0) ? S_IDLE : S_NEGA;
						default: state_q <= S_IDLE;
					endcase
				end
				S_NEGA: state_q <= S_NEGB;
				S_NEGB: state_q <= S_ITER;
				S_ITER: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					if (fix_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers: operands, accumulator or remainder, multiplier or quotient.
	always_ff @(posedge clk) begin
		case (state_q)
			S_LOAD: begin
				a_q   <= a_e;
				b_q   <= b_e;
				acc_q <= '0;
				q_q   <= b_e;
				neg_q <= cfg.is_signed & (a_e[DW-1] ^ b_e[DW-1]);
			end
			S_NEGA: begin
				if (cfg.is_signed && a_q[DW-1]) begin
					a_q <= sum[DW-1:0];
				end
			end
			S_NEGB: begin
				q_q   <= a_q;
				acc_q <= '0;
				if (cfg.is_signed && b_q[DW-1]) begin
					b_q <= sum[DW-1:0];
				end
			end
			S_ITER: begin
				if (cfg.op_select == OP_MUL) begin
					if (q_q[0]) begin
						acc_q <= sum[DW-1:0];
					end
					a_q <= a_q << 1;
					q_q <= q_q >> 1;
				end else begin
					acc_q <= sum_neg ? shifted[DW-1:0] : sum[DW-1:0];
					q_q   <= {q_q[DW-2:0], ~sum_neg};
				end
			end
			default: begin
			end
		endcase
		if (fix_load) begin
			res_q <= cfg.is_signed ? RESULT_W'($signed(r_e)) : RESULT_W'(r_e);
		end
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

`ifndef SYNTH
	// The last iteration always hands over to the finishing step.
	a_iter_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ITER && cnt_q == '0) |=> (state_q == S_FIX))
		else $error("iteration end did not reach finishing step");

	// A divide only finishes with a nonzero divisor magnitude.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIX && cfg.op_select == OP_DIV) |-> (b_q != '0))
		else $error("divide finished with zero divisor");

	// Work is only started while the unit is free.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (state_q == S_IDLE))
		else $error("start while busy");
`endif

endmodule

// ===== rtl/latched_two_operand_alu.sv =====
// Latched two-operand ALU: operand latching, configuration registers and result stream.
//
// Usage: each request on the s_axis channel writes operand a (tuser 0) or b (tuser 1).
// Once both operands have been written, every request yields one result on m_axis
// (add, subtract, multiply, divide, min or max at 8, 16, 32 or 64 bits, signed or
// unsigned). A divide by zero, an unused operation code, or a missing operand yields
// no result. Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// An accepted request registers a start, then the unit loads the operands; add,
// subtract, min and max go straight to the finishing step, multiply iterates first,
// and divide makes a and b positive, iterates, then finishes. A divide by zero or an
// unused operation code frees the block from the load step; a request that only
// latches a lone operand leaves the block ready on the next cycle.
// The next request is taken as soon as the arithmetic unit is free; its single
// shared adder runs one multiplier or quotient bit per cycle while it iterates.
// The result sits in an output register, so a stalled receiver does not stop the
// next computation; only a second finished result waits until the first is taken.
// Reset clears the operand-seen flags and the output valid, and returns the
// registers to add, 64-bit, signed.
module latched_two_operand_alu #(
	parameter int DATA_WIDTH = lta_pkg::DATA_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port.
	input  logic                            cfg_we,
	input  logic [lta_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lta_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Operand stream.
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [lta_pkg::OPERAND_W-1:0]   s_axis_tdata,  // [63:0] operand_value
	input  logic                            s_axis_tuser,  // [0] operand_port
	// Result stream.
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [lta_pkg::RESULT_W-1:0]    m_axis_tdata   // [63:0] result_value
);
	import lta_pkg::*;

	logic [OP_W-1:0]       op_select_q;
	logic [WCODE_W-1:0]    width_code_q;
	logic                  is_signed_q;
	logic [DATA_WIDTH-1:0] held_a_q;
	logic [DATA_WIDTH-1:0] held_b_q;
	logic                  seen_a_q;
	logic                  seen_b_q;
	logic                  go_q;
	logic                  accept;
	logic                  alu_idle;
	lta_cfg_t              cfg;

	assign accept        = s_axis_tvalid & s_axis_tready;
	assign s_axis_tready = alu_idle & ~go_q;

	assign cfg.op_select  = op_select_q;
	assign cfg.width_code = width_code_q;
	assign cfg.is_signed  = is_signed_q;

	// Configuration registers; writes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_select_q  <= OP_SELECT_RST;
			width_code_q <= WIDTH_CODE_RST;
			is_signed_q  <= IS_SIGNED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OP_SELECT:  op_select_q  <= cfg_data[OP_W-1:0];
				REG_WIDTH_CODE: width_code_q <= cfg_data[WCODE_W-1:0];
				REG_IS_SIGNED:  is_signed_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Seen flags and the start request for the arithmetic unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_a_q <= 1'b0;
			seen_b_q <= 1'b0;
			go_q     <= 1'b0;
		end else begin
			go_q <= accept & (seen_a_q | ~s_axis_tuser) & (seen_b_q | s_axis_tuser);
			if (accept) begin
				if (s_axis_tuser) begin
					seen_b_q <= 1'b1;
				end else begin
					seen_a_q <= 1'b1;
				end
			end
		end
	end

	// Operand holding registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (s_axis_tuser) begin
				held_b_q <= s_axis_tdata[DATA_WIDTH-1:0];
			end else begin
				held_a_q <= s_axis_tdata[DATA_WIDTH-1:0];
			end
		end
	end

	lta_alu #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_alu (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.start     (go_q),
		.a_raw     (held_a_q),
		.b_raw     (held_b_q),
		.idle      (alu_idle),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res_data  (m_axis_tdata)
	);

`ifndef SYNTH
	// A start request always takes the arithmetic unit out of idle.
	a_go_busy: assert property (@(posedge clk) disable iff (!arst_n)
		go_q |=> !alu_idle)
		else $error("start request did not occupy the arithmetic unit");

	// No new request is taken while a start request is pending.
	a_go_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		go_q |-> !s_axis_tready)
		else $error("request taken while a start request was pending");

	// A stalled result keeps its valid and its data.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed or was dropped");
`endif

endmodule
